@@ src/stk_pkg.sv @@
`default_nettype none

package stk_pkg;

  // Default number of stack entries.
  localparam int DEPTH_DEF = 16;

  // Width of one stored word.
  localparam int WORD_W = 32;

  // Operation codes carried on the mode port.
  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_READ   = 3'd3,
    MODE_INSERT = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // Shift command broadcast from the controller to every cell.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } stk_ctrl_t;

endpackage

`default_nettype wire

@@ src/stk_cell.sv @@
`default_nettype none

module stk_cell
  import stk_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int POS_W = 5
) (
  input  wire logic              clk,
  input  wire stk_ctrl_t         ctrl,
  input  wire logic [POS_W-1:0]  pos,
  input  wire logic [WORD_W-1:0] word_in,
  input  wire logic [WORD_W-1:0] up_data,
  input  wire logic [WORD_W-1:0] down_data,
  output logic [WORD_W-1:0]      data
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic [WORD_W-1:0] data_next;

  // On insert, the cell at the target depth loads the new word and every
  // deeper cell takes its upper neighbor. On pop, every cell takes its lower
  // neighbor.
  always_comb begin
    data_next = data;
    if (ctrl.ins_en) begin
      if (MY_IDX == pos) begin
        data_next = word_in;
      end else if (MY_IDX > pos) begin
        data_next = up_data;
      end
    end else if (ctrl.pop_en) begin
      data_next = down_data;
    end
  end

  // Entry storage; contents are undefined until written.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ src/lifo_stack_indexed_insert_unit.sv @@
`default_nettype none

// Bounded LIFO stack of signed 32-bit words with depth 0 at the top. It takes
// one operation (push, pop, peek, read at depth, insert at depth) on every
// clock cycle: busy is always low, and the result for an accepted operation
// is registered and presented with done high in the next cycle; sustained
// throughput is one operation per cycle. The entries live in a row of cells,
// one word each, that shift toward the bottom on push or insert and toward
// the top on pop, all in the same cycle; a read at depth selects one cell
// directly. The receiver cannot stall the block and must take each result in
// its done cycle. Count on the result port is the number of entries held
// after that operation. Only the fill count and done are cleared by reset.
module lifo_stack_indexed_insert_unit
  import stk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [2:0]                        mode,
  input  wire logic [$clog2(DEPTH+1)-1:0]        position,
  input  wire logic signed [WORD_W-1:0]          word_in,
  output logic                                   done,
  output logic signed [WORD_W-1:0]               word_out,
  output logic [1:0]                             status,
  output logic [$clog2(DEPTH+1)-1:0]             count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WORD_W-1:0] cell_data [DEPTH];

  logic              accept;
  logic              full;
  logic              empty;
  stk_ctrl_t         ctrl;
  logic [CNT_W-1:0]  ins_pos;
  logic [WORD_W-1:0] value_next;
  status_t           status_next;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  status_t           status_q;

  // A new operation is taken on every cycle.
  assign busy   = 1'b0;
  assign accept = start;

  assign full  = (fill_count == FULL_CNT);
  assign empty = (fill_count == '0);

  // Decode the operation into a shift command and a result.
  always_comb begin
    ctrl            = '0;
    ins_pos         = '0;
    value_next      = '0;
    status_next     = ST_OK;
    fill_count_next = fill_count;
    case (mode)
      MODE_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.pop_en = accept;
          value_next  = cell_data[0];
        end
      end
      MODE_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next = cell_data[0];
        end
      end
      MODE_READ: begin
        if (position >= fill_count) begin
          status_next = ST_BADIDX;
        end else begin
          value_next = cell_data[position[IDX_W-1:0]];
        end
      end
      MODE_INSERT: begin
        if (position > fill_count) begin
          status_next = ST_BADIDX;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          ins_pos     = position;
        end
      end
      default: begin
      end
    endcase
    if (ctrl.ins_en) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctrl.pop_en) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  // Row of storage cells; the top cell has no upper neighbor and the bottom
  // cell refills from itself on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_data;
    logic [WORD_W-1:0] down_data;

    if (i == 0) begin : g_top
      assign up_data = word_in;
    end else begin : g_mid_up
      assign up_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_data = cell_data[i];
    end else begin : g_mid_down
      assign down_data = cell_data[i+1];
    end

    stk_cell #(
      .INDEX (i),
      .POS_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (ins_pos),
      .word_in   (word_in),
      .up_data   (up_data),
      .down_data (down_data),
      .data      (cell_data[i])
    );
  end

  // Fill count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      done       <= accept;
    end
  end

  // Result payload of the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_out <= value_next;
      status_q <= status_next;
    end
  end

  assign status = status_q;
  assign count  = fill_count;

  // The fill count never exceeds the stack depth.
  assert property (@(posedge clk) disable iff (rst) fill_count <= FULL_CNT)
    else $error("fill count above depth");

  // Every accepted operation yields one result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> done)
    else $error("missing result strobe");

  // A push on a stack that is not full stores the word at the top.
  assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_PUSH && !full) |=>
      (cell_data[0] == $past(word_in) && fill_count == $past(fill_count) + CNT_W'(1)))
    else $error("push did not store at top");

  // A pop on an empty stack reports empty and leaves the count at zero.
  assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_POP && empty) |=> (status == ST_EMPTY && count == '0))
    else $error("pop on empty stack misreported");

  // Error results carry a zero word.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_BADIDX || status == ST_EMPTY || status == ST_FULL)) |->
      word_out == '0)
    else $error("nonzero word on error result");

endmodule

`default_nettype wire

@@ test/tb_lifo_stack_indexed_insert_unit.sv @@
`timescale 1ns / 1ps

module tb_lifo_stack_indexed_insert_unit;
  import stk_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int POS_W = $clog2(DEPTH + 1);
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_GAP = 40;

  // Mode codes that the block ignores.
  localparam logic [2:0] MODE_FIRST_SPARE = 3'd5;
  localparam logic [2:0] MODE_LAST_SPARE = 3'd7;

  // Traffic moods that steer the stack toward full, toward empty, or neither.
  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_MIXED
  } mood_t;

  // One expected reply of the stack.
  typedef struct {
    logic signed [WORD_W-1:0] word;
    logic [1:0]               stat;
    logic [POS_W-1:0]         cnt;
  } reply_t;

  // Shadow copy of the stack that predicts each reply and checks the real one.
  class stack_shadow;
    logic signed [WORD_W-1:0] slots [DEPTH];
    int unsigned              fill;
    reply_t                   due_replies [$];
    int                       mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Place a word at a depth, moving deeper entries down by one.
    function void place(int unsigned at, logic signed [WORD_W-1:0] w);
      for (int i = int'(fill); i > int'(at); i--) begin
        slots[i] = slots[i-1];
      end
      slots[at] = w;
      fill++;
    endfunction

    // Apply one accepted operation and queue the reply it should produce.
    function void apply_op(logic [2:0] op, logic [POS_W-1:0] pos,
                           logic signed [WORD_W-1:0] w);
      reply_t r;
      r.word = '0;
      r.stat = ST_OK;
      case (op)
        MODE_PUSH: begin
          if (fill >= DEPTH) r.stat = ST_FULL;
          else place(0, w);
        end
        MODE_POP: begin
          if (fill == 0) begin
            r.stat = ST_EMPTY;
          end else begin
            r.word = slots[0];
            for (int i = 0; i < int'(fill) - 1; i++) begin
              slots[i] = slots[i+1];
            end
            fill--;
          end
        end
        MODE_PEEK: begin
          if (fill == 0) r.stat = ST_EMPTY;
          else r.word = slots[0];
        end
        MODE_READ: begin
          if (pos >= fill) r.stat = ST_BADIDX;
          else r.word = slots[pos];
        end
        MODE_INSERT: begin
          // The depth check takes precedence over the full check.
          if (pos > fill) r.stat = ST_BADIDX;
          else if (fill >= DEPTH) r.stat = ST_FULL;
          else place(pos, w);
        end
        default: begin
        end
      endcase
      r.cnt = POS_W'(fill);
      due_replies.push_back(r);
    endfunction

    // Compare one reply from the block with the oldest expected reply.
    function void check_reply(logic signed [WORD_W-1:0] word, logic [1:0] stat,
                              logic [POS_W-1:0] cnt);
      reply_t r;
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual word %0d status %0d count %0d",
                 $time, word, stat, cnt);
        mismatches++;
        return;
      end
      r = due_replies.pop_front();
      if (word !== r.word) begin
        $display("%0t: word_out mismatch, expected %0d, actual %0d", $time, r.word, word);
        mismatches++;
      end
      if (stat !== r.stat) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.stat, stat);
        mismatches++;
      end
      if (cnt !== r.cnt) begin
        $display("%0t: count mismatch, expected %0d, actual %0d", $time, r.cnt, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [2:0]               mode = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] word_in = '0;
  logic                     busy;
  logic                     done;
  logic signed [WORD_W-1:0] word_out;
  logic [1:0]               status;
  logic [POS_W-1:0]         count;
  int                       stall_cycles = 0;

  stack_shadow shadow;

  lifo_stack_indexed_insert_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .position(position),
    .word_in(word_in),
    .done(done),
    .word_out(word_out),
    .status(status),
    .count(count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every reply is taken in its done cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      shadow.check_reply(word_out, status, count);
    end
  end

  // End the run if neither side makes progress for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("lifo_stack_indexed_insert_unit test failed");
        $finish;
      end
    end
  end

  // Offer one operation, after a random gap, and hold it until the transfer.
  task automatic send_op(input logic [2:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [WORD_W-1:0] w, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    mode <= op;
    position <= pos;
    word_in <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.apply_op(op, pos, w);
  endtask

  // Stop offering work until every outstanding reply has come back.
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.due_replies.size() != 0) @(posedge clk);
  endtask

  // Edge cases: empty stack errors, extreme words, bottom and middle inserts,
  // a full stack and reads at its last valid and first invalid depths.
  task automatic run_directed();
    send_op(MODE_POP, '0, '0, 0);
    send_op(MODE_PEEK, '0, '0, 0);
    send_op(MODE_READ, '0, '0, 0);
    send_op(MODE_INSERT, POS_W'(1), 32'sd5, 0);
    send_op(MODE_INSERT, '0, 32'h8000_0000, 0);
    send_op(MODE_PUSH, POS_W'(POS_MAX), 32'h7FFF_FFFF, 0);
    send_op(MODE_INSERT, POS_W'(2), 32'hFFFF_FFFF, 0);
    send_op(MODE_READ, POS_W'(2), '0, 0);
    send_op(MODE_INSERT, POS_W'(1), '0, 0);
    send_op(MODE_LAST_SPARE, POS_W'(POS_MAX), 32'h1234_5678, 0);
    while (shadow.fill < DEPTH) begin
      send_op(MODE_PUSH, '0, $urandom, 0);
    end
    send_op(MODE_PUSH, '0, $urandom, 0);
    send_op(MODE_INSERT, POS_W'(5), $urandom, 0);
    send_op(MODE_INSERT, POS_W'(DEPTH + 1), $urandom, 0);
    send_op(MODE_READ, POS_W'(DEPTH - 1), '0, 0);
    send_op(MODE_READ, POS_W'(DEPTH), '0, 0);
  endtask

  // Random operations whose mix drifts between filling and draining the stack.
  task automatic run_random(input int n_items, input int idle_pct);
    mood_t             mood;
    int                mood_left;
    int                grow_pct;
    int                shrink_pct;
    int                roll;
    logic [2:0]        op;
    logic [POS_W-1:0]  pos;
    mood = MOOD_MIXED;
    mood_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (mood_left == 0) begin
        mood = mood_t'($urandom_range(2));
        mood_left = $urandom_range(10, 50);
      end
      mood_left--;
      case (mood)
        MOOD_FILL: begin
          grow_pct = 60;
          shrink_pct = 12;
        end
        MOOD_DRAIN: begin
          grow_pct = 20;
          shrink_pct = 50;
        end
        default: begin
          grow_pct = 40;
          shrink_pct = 30;
        end
      endcase

      roll = $urandom_range(99);
      if (roll < 3) begin
        op = 3'($urandom_range(MODE_FIRST_SPARE, MODE_LAST_SPARE));
      end else if (roll < 3 + grow_pct) begin
        op = $urandom_range(1) ? MODE_PUSH : MODE_INSERT;
      end else if (roll < 3 + grow_pct + shrink_pct) begin
        op = MODE_POP;
      end else begin
        op = ($urandom_range(2) == 0) ? MODE_PEEK : MODE_READ;
      end

      // Depths are mostly valid, with some anywhere in the field's range.
      pos = POS_W'($urandom_range(POS_MAX));
      if ($urandom_range(99) < 85) begin
        if (op == MODE_INSERT) begin
          pos = POS_W'($urandom_range(shadow.fill));
        end else if (op == MODE_READ && shadow.fill > 0) begin
          pos = POS_W'($urandom_range(shadow.fill - 1));
        end
      end
      send_op(op, pos, $urandom, idle_pct);
    end
  endtask

  initial begin
    shadow = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain_replies();

    // Phases of sender idling; the receiver cannot stall, so its phase runs flat out.
    run_random(300, 0);
    drain_replies();
    run_random(280, 73);
    drain_replies();
    run_random(280, 0);
    drain_replies();
    run_random(265, 6);

    drain_replies();
    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.due_replies.size() == 0) begin
      $display("lifo_stack_indexed_insert_unit test passed");
    end else begin
      $display("lifo_stack_indexed_insert_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/stk_pkg.sv
src/stk_cell.sv
src/lifo_stack_indexed_insert_unit.sv
test/tb_lifo_stack_indexed_insert_unit.sv
